// ===== hdl/tatn_pkg.sv =====
package tatn_pkg;

   localparam int IN_W = 16;
   localparam int OUT_W = 16;
   localparam int NORM_W = 35;
   localparam int ROW_W = 64;
   localparam int COEF_W = 16;
   localparam int PROD_W = 2 * COEF_W;
   localparam int ACC_W = PROD_W + 2;
   localparam int FRAC_SHIFT = 12;
   localparam int Q_W = ACC_W - FRAC_SHIFT;
   localparam int TRANS_LSB = 48;
   localparam int NUM_ROWS = 3;
   localparam int NUM_CORNERS = 3;
   localparam int NUM_STAGES = 5;
   localparam int CSR_INDEX_W = 2;

   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2048);

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_Z = 2'd2;

   localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;

   typedef logic [NUM_ROWS-1:0][ROW_W-1:0] matrix_type;

   typedef struct packed {
      logic load_mul;
      logic load_sum;
      logic load_diff;
      logic load_prod;
      logic load_out;
   } pipe_ctrl_type;

endpackage

// ===== hdl/tatn_if.sv =====
interface tatn_req_if;
   logic valid;
   logic ready;
   logic signed [tatn_pkg::IN_W-1:0] corner_a_x;
   logic signed [tatn_pkg::IN_W-1:0] corner_a_y;
   logic signed [tatn_pkg::IN_W-1:0] corner_a_z;
   logic signed [tatn_pkg::IN_W-1:0] corner_b_x;
   logic signed [tatn_pkg::IN_W-1:0] corner_b_y;
   logic signed [tatn_pkg::IN_W-1:0] corner_b_z;
   logic signed [tatn_pkg::IN_W-1:0] corner_c_x;
   logic signed [tatn_pkg::IN_W-1:0] corner_c_y;
   logic signed [tatn_pkg::IN_W-1:0] corner_c_z;

   modport source (
      output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
         corner_b_z, corner_c_x, corner_c_y, corner_c_z,
      input ready
   );
   modport sink (
      input valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
         corner_b_z, corner_c_x, corner_c_y, corner_c_z,
      output ready
   );
endinterface

interface tatn_rsp_if;
   logic valid;
   logic ready;
   logic signed [tatn_pkg::OUT_W-1:0] out_a_x;
   logic signed [tatn_pkg::OUT_W-1:0] out_a_y;
   logic signed [tatn_pkg::OUT_W-1:0] out_a_z;
   logic signed [tatn_pkg::OUT_W-1:0] out_b_x;
   logic signed [tatn_pkg::OUT_W-1:0] out_b_y;
   logic signed [tatn_pkg::OUT_W-1:0] out_b_z;
   logic signed [tatn_pkg::OUT_W-1:0] out_c_x;
   logic signed [tatn_pkg::OUT_W-1:0] out_c_y;
   logic signed [tatn_pkg::OUT_W-1:0] out_c_z;
   logic signed [tatn_pkg::NORM_W-1:0] normal_x;
   logic signed [tatn_pkg::NORM_W-1:0] normal_y;
   logic signed [tatn_pkg::NORM_W-1:0] normal_z;

   modport source (
      output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
         out_c_x, out_c_y, out_c_z, normal_x, normal_y, normal_z,
      input ready
   );
   modport sink (
      input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
         out_c_x, out_c_y, out_c_z, normal_x, normal_y, normal_z,
      output ready
   );
endinterface

// ===== hdl/triangle_affine_transform_normal_core.sv =====
// Transforms one triangle per transfer: each corner goes through the three configured affine
// rows (Q4.12 coefficients, Q8.8 translation), is rounded to Q8.8 and saturated, and the
// unnormalized face normal cross(A-B, B-C) is formed from the transformed corners. The block
// accepts one triangle every cycle while a stage is free, and runs it through a
// five-stage pipeline of three corner lanes (products, then sum, round and clamp) followed by
// the normal stages (differences, products, final subtract into the output register). Each
// stage holds its item under back-pressure and empty stages fill, so input is still taken
// while a result waits as long as a stage is free. The matrix rows reset to the identity and
// should be written only while the pipeline is empty.
module triangle_affine_transform_normal_core #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   tatn_req_if.sink req_chan,
   tatn_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [tatn_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tatn_pkg::ROW_W-1:0] csr_wdata
);

   localparam int EW = (COORD_WIDTH > tatn_pkg::OUT_W) ? COORD_WIDTH : tatn_pkg::OUT_W;

   tatn_pkg::matrix_type row_ff;
   logic [tatn_pkg::NUM_STAGES-1:0] valid_ff;
   logic [tatn_pkg::NUM_STAGES-1:0] valid_in;
   logic [tatn_pkg::NUM_STAGES-1:0] load;
   tatn_pkg::pipe_ctrl_type ctrl;

   logic signed [tatn_pkg::IN_W-1:0] in_pos [tatn_pkg::NUM_CORNERS][3];
   logic signed [COORD_WIDTH-1:0] lane_res [tatn_pkg::NUM_CORNERS][3];
   logic signed [COORD_WIDTH-1:0] final_pos [tatn_pkg::NUM_CORNERS][3];
   logic signed [EW-1:0] final_ext [tatn_pkg::NUM_CORNERS][3];
   logic signed [tatn_pkg::OUT_W-1:0] out_pos [tatn_pkg::NUM_CORNERS][3];
   logic signed [tatn_pkg::NORM_W-1:0] normal [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= tatn_pkg::ROW_X_RESET;
         row_ff[1] <= tatn_pkg::ROW_Y_RESET;
         row_ff[2] <= tatn_pkg::ROW_Z_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tatn_pkg::CSR_ROW_X: row_ff[0] <= csr_wdata;
            tatn_pkg::CSR_ROW_Y: row_ff[1] <= csr_wdata;
            tatn_pkg::CSR_ROW_Z: row_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A stage loads when it is empty or its contents move on in the same cycle.
   always_comb begin
      load[tatn_pkg::NUM_STAGES-1] = !valid_ff[tatn_pkg::NUM_STAGES-1] || rsp_chan.ready;
      for (int s = tatn_pkg::NUM_STAGES - 2; s >= 0; s--) begin
         load[s] = !valid_ff[s] || load[s+1];
      end
      valid_in[0] = load[0] ? req_chan.valid : valid_ff[0];
      for (int s = 1; s < tatn_pkg::NUM_STAGES; s++) begin
         valid_in[s] = load[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      ctrl.load_mul = load[0];
      ctrl.load_sum = load[1];
      ctrl.load_diff = load[2];
      ctrl.load_prod = load[3];
      ctrl.load_out = load[4];
   end

   assign req_chan.ready = load[0];
   assign rsp_chan.valid = valid_ff[tatn_pkg::NUM_STAGES-1];

   always_comb begin
      in_pos[0][0] = req_chan.corner_a_x;
      in_pos[0][1] = req_chan.corner_a_y;
      in_pos[0][2] = req_chan.corner_a_z;
      in_pos[1][0] = req_chan.corner_b_x;
      in_pos[1][1] = req_chan.corner_b_y;
      in_pos[1][2] = req_chan.corner_b_z;
      in_pos[2][0] = req_chan.corner_c_x;
      in_pos[2][1] = req_chan.corner_c_y;
      in_pos[2][2] = req_chan.corner_c_z;
   end

   for (genvar k = 0; k < tatn_pkg::NUM_CORNERS; k++) begin : g_lane
      tatn_corner_lane #(
         .COORD_WIDTH(COORD_WIDTH)
      ) u_lane (
         .clock(clock),
         .ctrl(ctrl),
         .rows(row_ff),
         .pos_x(in_pos[k][0]),
         .pos_y(in_pos[k][1]),
         .pos_z(in_pos[k][2]),
         .res(lane_res[k])
      );
   end

   tatn_face_normal #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_normal (
      .clock(clock),
      .ctrl(ctrl),
      .corner(lane_res),
      .corner_out(final_pos),
      .normal(normal)
   );

   always_comb begin
      for (int k = 0; k < tatn_pkg::NUM_CORNERS; k++) begin
         for (int a = 0; a < 3; a++) begin
            final_ext[k][a] = EW'(final_pos[k][a]);
            out_pos[k][a] = final_ext[k][a][tatn_pkg::OUT_W-1:0];
         end
      end
   end

   assign rsp_chan.out_a_x = out_pos[0][0];
   assign rsp_chan.out_a_y = out_pos[0][1];
   assign rsp_chan.out_a_z = out_pos[0][2];
   assign rsp_chan.out_b_x = out_pos[1][0];
   assign rsp_chan.out_b_y = out_pos[1][1];
   assign rsp_chan.out_b_z = out_pos[1][2];
   assign rsp_chan.out_c_x = out_pos[2][0];
   assign rsp_chan.out_c_y = out_pos[2][1];
   assign rsp_chan.out_c_z = out_pos[2][2];
   assign rsp_chan.normal_x = normal[0];
   assign rsp_chan.normal_y = normal[1];
   assign rsp_chan.normal_z = normal[2];

`ifndef NO_ASSERTIONS
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("Input taken while every stage is held.");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_ff[0])
      else $error("Accepted triangle did not enter the first stage.");

   a_last_moves: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && (rsp_chan.ready || !valid_ff[4])) |=> rsp_chan.valid)
      else $error("Triangle lost between the product and output stages.");

   a_reset_identity: assert property (@(posedge clock)
      reset |=> (row_ff[0] == tatn_pkg::ROW_X_RESET && row_ff[1] == tatn_pkg::ROW_Y_RESET
                 && row_ff[2] == tatn_pkg::ROW_Z_RESET && valid_ff == '0))
      else $error("Matrix or pipeline not cleared by reset.");
`endif

endmodule

// ===== hdl/tatn_corner_lane.sv =====
module tatn_corner_lane #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  tatn_pkg::pipe_ctrl_type ctrl,
   input  tatn_pkg::matrix_type rows,
   input  logic signed [tatn_pkg::IN_W-1:0] pos_x,
   input  logic signed [tatn_pkg::IN_W-1:0] pos_y,
   input  logic signed [tatn_pkg::IN_W-1:0] pos_z,
   output logic signed [COORD_WIDTH-1:0] res [tatn_pkg::NUM_ROWS]
);

   localparam int SW = (COORD_WIDTH > tatn_pkg::Q_W) ? COORD_WIDTH : tatn_pkg::Q_W;
   localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

   logic signed [tatn_pkg::IN_W-1:0] coord [3];
   logic signed [tatn_pkg::COEF_W-1:0] coef [tatn_pkg::NUM_ROWS][3];
   logic signed [tatn_pkg::COEF_W-1:0] trans [tatn_pkg::NUM_ROWS];
   logic signed [tatn_pkg::PROD_W-1:0] prod_in [tatn_pkg::NUM_ROWS][3];
   logic signed [tatn_pkg::PROD_W-1:0] prod_ff [tatn_pkg::NUM_ROWS][3];
   logic signed [tatn_pkg::ACC_W-1:0] acc [tatn_pkg::NUM_ROWS];
   logic signed [tatn_pkg::Q_W-1:0] quot [tatn_pkg::NUM_ROWS];
   logic signed [SW-1:0] quot_ext [tatn_pkg::NUM_ROWS];
   logic signed [SW-1:0] sat [tatn_pkg::NUM_ROWS];
   logic signed [COORD_WIDTH-1:0] res_in [tatn_pkg::NUM_ROWS];
   logic signed [COORD_WIDTH-1:0] res_ff [tatn_pkg::NUM_ROWS];

   always_comb begin
      coord[0] = pos_x;
      coord[1] = pos_y;
      coord[2] = pos_z;
      for (int r = 0; r < tatn_pkg::NUM_ROWS; r++) begin
         trans[r] = signed'(rows[r][tatn_pkg::TRANS_LSB +: tatn_pkg::COEF_W]);
         for (int c = 0; c < 3; c++) begin
            coef[r][c] = signed'(rows[r][tatn_pkg::COEF_W*c +: tatn_pkg::COEF_W]);
            prod_in[r][c] = coef[r][c] * coord[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_mul) begin
         prod_ff <= prod_in;
      end
   end

   // Floor of the rounded sum by 4096 is an arithmetic shift by twelve.
   always_comb begin
      for (int r = 0; r < tatn_pkg::NUM_ROWS; r++) begin
         acc[r] = tatn_pkg::ACC_W'(prod_ff[r][0]) + tatn_pkg::ACC_W'(prod_ff[r][1])
            + tatn_pkg::ACC_W'(prod_ff[r][2])
            + (tatn_pkg::ACC_W'(trans[r]) <<< tatn_pkg::FRAC_SHIFT)
            + tatn_pkg::ROUND_BIAS;
         quot[r] = acc[r][tatn_pkg::ACC_W-1:tatn_pkg::FRAC_SHIFT];
         quot_ext[r] = SW'(quot[r]);
         if (quot_ext[r] > SAT_HI) begin
            sat[r] = SAT_HI;
         end else if (quot_ext[r] < SAT_LO) begin
            sat[r] = SAT_LO;
         end else begin
            sat[r] = quot_ext[r];
         end
         res_in[r] = sat[r][COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_sum) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== hdl/tatn_face_normal.sv =====
module tatn_face_normal #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  tatn_pkg::pipe_ctrl_type ctrl,
   input  logic signed [COORD_WIDTH-1:0] corner [tatn_pkg::NUM_CORNERS][3],
   output logic signed [COORD_WIDTH-1:0] corner_out [tatn_pkg::NUM_CORNERS][3],
   output logic signed [tatn_pkg::NORM_W-1:0] normal [3]
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PRW = 2 * DW;
   localparam int XW = (PRW + 1 > tatn_pkg::NORM_W) ? PRW + 1 : tatn_pkg::NORM_W;
   localparam int NEXT1 [3] = '{1, 2, 0};
   localparam int NEXT2 [3] = '{2, 0, 1};

   logic signed [COORD_WIDTH-1:0] pos_diff_ff [tatn_pkg::NUM_CORNERS][3];
   logic signed [COORD_WIDTH-1:0] pos_prod_ff [tatn_pkg::NUM_CORNERS][3];
   logic signed [COORD_WIDTH-1:0] pos_out_ff [tatn_pkg::NUM_CORNERS][3];
   logic signed [DW-1:0] u_in [3];
   logic signed [DW-1:0] v_in [3];
   logic signed [DW-1:0] u_ff [3];
   logic signed [DW-1:0] v_ff [3];
   logic signed [PRW-1:0] term_in [3][2];
   logic signed [PRW-1:0] term_ff [3][2];
   logic signed [XW-1:0] norm_full [3];
   logic signed [tatn_pkg::NORM_W-1:0] normal_in [3];
   logic signed [tatn_pkg::NORM_W-1:0] normal_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_in[k] = DW'(corner[0][k]) - DW'(corner[1][k]);
         v_in[k] = DW'(corner[1][k]) - DW'(corner[2][k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_diff) begin
         u_ff <= u_in;
         v_ff <= v_in;
         pos_diff_ff <= corner;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term_in[k][0] = u_ff[NEXT1[k]] * v_ff[NEXT2[k]];
         term_in[k][1] = u_ff[NEXT2[k]] * v_ff[NEXT1[k]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         term_ff <= term_in;
         pos_prod_ff <= pos_diff_ff;
      end
   end

   // Wider configurations wrap the normal modulo the output width.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         norm_full[k] = XW'(term_ff[k][0]) - XW'(term_ff[k][1]);
         normal_in[k] = norm_full[k][tatn_pkg::NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         normal_ff <= normal_in;
         pos_out_ff <= pos_prod_ff;
      end
   end

   assign normal = normal_ff;
   assign corner_out = pos_out_ff;

endmodule

// ===== tb/triangle_affine_transform_normal_core_tb.sv =====
`timescale 1ns / 1ps

module triangle_affine_transform_normal_core_tb;

   localparam int COORD_W = 16;
   localparam int ITEMS_PER_PHASE = 118;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [tatn_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {SET_RESET, SET_HALF, SET_MAX, SET_MIN} matrix_setting_type;
   typedef enum int {MAT_IDENTITY, MAT_MODERATE, MAT_FULL, MAT_MAX, MAT_MIN} matrix_kind_type;

   typedef struct packed {
      logic signed [tatn_pkg::IN_W-1:0] x;
      logic signed [tatn_pkg::IN_W-1:0] y;
      logic signed [tatn_pkg::IN_W-1:0] z;
   } in_point_type;

   typedef struct packed {
      in_point_type a;
      in_point_type b;
      in_point_type c;
   } triangle_type;

   typedef struct packed {
      logic signed [tatn_pkg::OUT_W-1:0] x;
      logic signed [tatn_pkg::OUT_W-1:0] y;
      logic signed [tatn_pkg::OUT_W-1:0] z;
   } out_point_type;

   typedef struct packed {
      out_point_type a;
      out_point_type b;
      out_point_type c;
      logic signed [tatn_pkg::NORM_W-1:0] nx;
      logic signed [tatn_pkg::NORM_W-1:0] ny;
      logic signed [tatn_pkg::NORM_W-1:0] nz;
   } tri_result_type;

   typedef struct {
      matrix_setting_type setting;
      triangle_type shape;
      bit typed;
      tri_result_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [tatn_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tatn_pkg::ROW_W-1:0] csr_wdata = '0;

   tatn_req_if req_bus ();
   tatn_rsp_if rsp_bus ();

   triangle_affine_transform_normal_core uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   tatn_pkg::matrix_type active_matrix = {tatn_pkg::ROW_Z_RESET, tatn_pkg::ROW_Y_RESET,
                                          tatn_pkg::ROW_X_RESET};
   tri_result_type expected_q[$];
   directed_row_type directed_rows[$];
   int mismatches = 0;
   int idle_cycles_ff = 0;
   bit src_steady = 1'b0;
   bit snk_steady = 1'b0;
   matrix_kind_type phase_plan[8] = '{MAT_MODERATE, MAT_FULL, MAT_MODERATE, MAT_MAX,
                                      MAT_IDENTITY, MAT_MODERATE, MAT_MIN, MAT_MODERATE};

   initial begin
      req_bus.valid = 1'b0;
      req_bus.corner_a_x = '0;
      req_bus.corner_a_y = '0;
      req_bus.corner_a_z = '0;
      req_bus.corner_b_x = '0;
      req_bus.corner_b_y = '0;
      req_bus.corner_b_z = '0;
      req_bus.corner_c_x = '0;
      req_bus.corner_c_y = '0;
      req_bus.corner_c_z = '0;
      rsp_bus.ready = 1'b0;
   end

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [tatn_pkg::ROW_W-1:0] pack_row(logic [15:0] cx, logic [15:0] cy,
                                                           logic [15:0] cz, logic [15:0] tr);
      return {tr, cz, cy, cx};
   endfunction

   function automatic longint transform_coord(logic [tatn_pkg::ROW_W-1:0] row,
                                              in_point_type p);
      longint cx, cy, cz, tr, px, py, pz, acc, q, hi, lo;
      cx = $signed(row[15:0]);
      cy = $signed(row[31:16]);
      cz = $signed(row[47:32]);
      tr = $signed(row[63:48]);
      px = p.x;
      py = p.y;
      pz = p.z;
      acc = cx * px + cy * py + cz * pz + tr * 4096 + 2048;
      q = acc >>> tatn_pkg::FRAC_SHIFT;
      hi = (longint'(1) <<< (COORD_W - 1)) - 1;
      lo = -hi - 1;
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return q;
   endfunction

   function automatic tri_result_type transform_triangle(tatn_pkg::matrix_type m,
                                                         triangle_type t);
      in_point_type pts[3];
      longint p[3][3];
      longint u[3];
      longint v[3];
      tri_result_type r;
      pts[0] = t.a;
      pts[1] = t.b;
      pts[2] = t.c;
      for (int k = 0; k < tatn_pkg::NUM_CORNERS; k++) begin
         for (int row = 0; row < tatn_pkg::NUM_ROWS; row++) begin
            p[k][row] = transform_coord(m[row], pts[k]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         u[k] = p[0][k] - p[1][k];
         v[k] = p[1][k] - p[2][k];
      end
      r.a.x = tatn_pkg::OUT_W'(p[0][0]);
      r.a.y = tatn_pkg::OUT_W'(p[0][1]);
      r.a.z = tatn_pkg::OUT_W'(p[0][2]);
      r.b.x = tatn_pkg::OUT_W'(p[1][0]);
      r.b.y = tatn_pkg::OUT_W'(p[1][1]);
      r.b.z = tatn_pkg::OUT_W'(p[1][2]);
      r.c.x = tatn_pkg::OUT_W'(p[2][0]);
      r.c.y = tatn_pkg::OUT_W'(p[2][1]);
      r.c.z = tatn_pkg::OUT_W'(p[2][2]);
      r.nx = tatn_pkg::NORM_W'(u[1] * v[2] - u[2] * v[1]);
      r.ny = tatn_pkg::NORM_W'(u[2] * v[0] - u[0] * v[2]);
      r.nz = tatn_pkg::NORM_W'(u[0] * v[1] - u[1] * v[0]);
      return r;
   endfunction

   function automatic tatn_pkg::matrix_type setting_matrix(matrix_setting_type s);
      tatn_pkg::matrix_type m;
      case (s)
         SET_HALF: begin
            m[0] = pack_row(16'h0800, 16'h0000, 16'h0000, 16'h0000);
            m[1] = pack_row(16'h0000, 16'h0800, 16'h0000, 16'h0000);
            m[2] = pack_row(16'h0000, 16'h0000, 16'h0800, 16'h0000);
         end
         SET_MAX: begin
            for (int row = 0; row < tatn_pkg::NUM_ROWS; row++) begin
               m[row] = pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
            end
         end
         SET_MIN: begin
            for (int row = 0; row < tatn_pkg::NUM_ROWS; row++) begin
               m[row] = pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000);
            end
         end
         default: begin
            m = {tatn_pkg::ROW_Z_RESET, tatn_pkg::ROW_Y_RESET, tatn_pkg::ROW_X_RESET};
         end
      endcase
      return m;
   endfunction

   function automatic tatn_pkg::matrix_type random_matrix(matrix_kind_type kind);
      tatn_pkg::matrix_type m;
      case (kind)
         MAT_IDENTITY: m = setting_matrix(SET_RESET);
         MAT_MAX: m = setting_matrix(SET_MAX);
         MAT_MIN: m = setting_matrix(SET_MIN);
         MAT_FULL: begin
            for (int row = 0; row < tatn_pkg::NUM_ROWS; row++) begin
               m[row] = {$urandom, $urandom};
            end
         end
         default: begin
            for (int row = 0; row < tatn_pkg::NUM_ROWS; row++) begin
               m[row] = pack_row(16'($urandom_range(0, 16384) - 8192),
                                 16'($urandom_range(0, 16384) - 8192),
                                 16'($urandom_range(0, 16384) - 8192),
                                 16'($urandom_range(0, 8192) - 4096));
            end
         end
      endcase
      return m;
   endfunction

   function automatic in_point_type pt(int x, int y, int z);
      in_point_type p;
      p.x = tatn_pkg::IN_W'(x);
      p.y = tatn_pkg::IN_W'(y);
      p.z = tatn_pkg::IN_W'(z);
      return p;
   endfunction

   function automatic directed_row_type pred_row(matrix_setting_type s, in_point_type a,
                                                 in_point_type b, in_point_type c);
      directed_row_type r;
      r.setting = s;
      r.shape = '{a: a, b: b, c: c};
      r.typed = 1'b0;
      r.want = '0;
      return r;
   endfunction

   // Under the identity transform every corner comes back unchanged.
   function automatic directed_row_type echo_row(in_point_type a, in_point_type b,
                                                 in_point_type c,
                                                 longint nx, longint ny, longint nz);
      directed_row_type r;
      r.setting = SET_RESET;
      r.shape = '{a: a, b: b, c: c};
      r.typed = 1'b1;
      r.want.a = '{x: a.x, y: a.y, z: a.z};
      r.want.b = '{x: b.x, y: b.y, z: b.z};
      r.want.c = '{x: c.x, y: c.y, z: c.z};
      r.want.nx = tatn_pkg::NORM_W'(nx);
      r.want.ny = tatn_pkg::NORM_W'(ny);
      r.want.nz = tatn_pkg::NORM_W'(nz);
      return r;
   endfunction

   // All nine coordinates equal and all saturating to the same end of the range.
   function automatic directed_row_type clamp_row(matrix_setting_type s, int in_value,
                                                  int out_value);
      directed_row_type r;
      out_point_type o;
      r.setting = s;
      r.shape = '{a: pt(in_value, in_value, in_value), b: pt(in_value, in_value, in_value),
                  c: pt(in_value, in_value, in_value)};
      r.typed = 1'b1;
      o.x = tatn_pkg::OUT_W'(out_value);
      o.y = tatn_pkg::OUT_W'(out_value);
      o.z = tatn_pkg::OUT_W'(out_value);
      r.want.a = o;
      r.want.b = o;
      r.want.c = o;
      r.want.nx = '0;
      r.want.ny = '0;
      r.want.nz = '0;
      return r;
   endfunction

   function automatic logic [tatn_pkg::IN_W-1:0] random_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return tatn_pkg::IN_W'($urandom_range(0, 8192) - 4096);
      if (pick < 8) return tatn_pkg::IN_W'($urandom);
      if (pick == 8) begin
         case ($urandom_range(0, 3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'hFFFF;
         endcase
      end
      return tatn_pkg::IN_W'($urandom_range(0, 32) - 16);
   endfunction

   function automatic in_point_type random_point();
      in_point_type p;
      p.x = random_coord();
      p.y = random_coord();
      p.z = random_coord();
      return p;
   endfunction

   function automatic triangle_type random_triangle();
      triangle_type t;
      t.a = random_point();
      t.b = random_point();
      t.c = random_point();
      case ($urandom_range(0, 9))
         0: t.c = t.b;
         1: t.b = t.a;
         2: t.c = t.a;
         default: ;
      endcase
      return t;
   endfunction

   function automatic int draw_wait(bit steady);
      return steady ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic void add_row(directed_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   task automatic send_triangle(triangle_type t, bit typed, tri_result_type want);
      int gap;
      gap = draw_wait(src_steady);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.corner_a_x <= t.a.x;
      req_bus.corner_a_y <= t.a.y;
      req_bus.corner_a_z <= t.a.z;
      req_bus.corner_b_x <= t.b.x;
      req_bus.corner_b_y <= t.b.y;
      req_bus.corner_b_z <= t.b.z;
      req_bus.corner_c_x <= t.c.x;
      req_bus.corner_c_y <= t.c.y;
      req_bus.corner_c_z <= t.c.z;
      do @(posedge clock); while (!req_bus.ready);
      expected_q.insert(expected_q.size(),
                        typed ? want : transform_triangle(active_matrix, t));
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_row(logic [tatn_pkg::CSR_INDEX_W-1:0] index,
                            logic [tatn_pkg::ROW_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == tatn_pkg::CSR_ROW_X) active_matrix[0] = value;
      else if (index == tatn_pkg::CSR_ROW_Y) active_matrix[1] = value;
      else if (index == tatn_pkg::CSR_ROW_Z) active_matrix[2] = value;
   endtask

   // The write to the unused index must leave the matrix untouched.
   task automatic load_matrix(tatn_pkg::matrix_type m);
      write_row(tatn_pkg::CSR_ROW_X, m[0]);
      write_row(CSR_UNUSED, {$urandom, $urandom});
      write_row(tatn_pkg::CSR_ROW_Y, m[1]);
      write_row(tatn_pkg::CSR_ROW_Z, m[2]);
      csr_we <= 1'b0;
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles_ff <= 0;
      end else begin
         idle_cycles_ff <= idle_cycles_ff + 1;
      end
      if (idle_cycles_ff >= WATCHDOG_LIMIT) begin
         $display("triangle_affine_transform_normal_core_tb: FAIL");
         $finish;
      end
   end

   initial begin
      tri_result_type got;
      tri_result_type want;
      int stall;
      wait (!reset);
      forever begin
         stall = draw_wait(snk_steady);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.a = '{x: rsp_bus.out_a_x, y: rsp_bus.out_a_y, z: rsp_bus.out_a_z};
         got.b = '{x: rsp_bus.out_b_x, y: rsp_bus.out_b_y, z: rsp_bus.out_b_z};
         got.c = '{x: rsp_bus.out_c_x, y: rsp_bus.out_c_y, z: rsp_bus.out_c_z};
         got.nx = rsp_bus.normal_x;
         got.ny = rsp_bus.normal_y;
         got.nz = rsp_bus.normal_z;
         if (expected_q.size() == 0) begin
            $error("result transfer with no triangle outstanding");
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            check_field("out_a_x", want.a.x, got.a.x);
            check_field("out_a_y", want.a.y, got.a.y);
            check_field("out_a_z", want.a.z, got.a.z);
            check_field("out_b_x", want.b.x, got.b.x);
            check_field("out_b_y", want.b.y, got.b.y);
            check_field("out_b_z", want.b.z, got.b.z);
            check_field("out_c_x", want.c.x, got.c.x);
            check_field("out_c_y", want.c.y, got.c.y);
            check_field("out_c_z", want.c.z, got.c.z);
            check_field("normal_x", want.nx, got.nx);
            check_field("normal_y", want.ny, got.ny);
            check_field("normal_z", want.nz, got.nz);
         end
      end
   end

   initial begin
      matrix_setting_type current;
      directed_row_type row;
      tri_result_type none;
      none = '0;

      add_row(echo_row(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), 0, 0, 0));
      add_row(echo_row(pt(256, 0, 0), pt(0, 0, 0), pt(0, 256, 0), 0, 0, -65536));
      add_row(echo_row(pt(32767, 32767, 32767), pt(-32768, -32768, -32768),
                       pt(-32768, -32768, -32768), 0, 0, 0));
      add_row(echo_row(pt(0, 0, 0), pt(256, 256, 256), pt(512, 512, 512), 0, 0, 0));
      add_row(echo_row(pt(0, 256, 0), pt(0, 0, 256), pt(256, 0, 0), 65536, 65536, 65536));
      add_row(pred_row(SET_RESET, pt(32767, -32768, 0), pt(-32768, 32767, 32767),
                       pt(32767, 32767, -32768)));
      add_row(pred_row(SET_RESET, pt(4660, -1383, 28672), pt(-20000, 12345, -7),
                       pt(1, -1, 255)));
      add_row(pred_row(SET_HALF, pt(1, -1, 3), pt(-3, 2, -2), pt(5, -5, 0)));
      add_row(pred_row(SET_HALF, pt(32767, -32768, -1), pt(-32767, 32766, 1), pt(2, -2, 0)));
      add_row(clamp_row(SET_MAX, 32767, 32767));
      add_row(clamp_row(SET_MAX, -32768, -32768));
      add_row(pred_row(SET_MAX, pt(256, 0, 0), pt(0, 256, 0), pt(0, 0, -256)));
      add_row(pred_row(SET_MAX, pt(-1, 0, 0), pt(0, 0, 0), pt(0, -1, 0)));
      add_row(clamp_row(SET_MIN, 32767, -32768));
      add_row(clamp_row(SET_MIN, -32768, 32767));
      add_row(pred_row(SET_MIN, pt(-1, 1, 0), pt(0, 0, 0), pt(1, 1, 1)));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      current = SET_RESET;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.setting != current) begin
            drain_results();
            load_matrix(setting_matrix(row.setting));
            current = row.setting;
         end
         send_triangle(row.shape, row.typed, row.want);
      end

      foreach (phase_plan[p]) begin
         drain_results();
         load_matrix(random_matrix(phase_plan[p]));
         src_steady = ($urandom_range(0, 3) == 0);
         snk_steady = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_triangle(random_triangle(), 1'b0, none);
         end
      end

      drain_results();
      repeat (2 * tatn_pkg::NUM_STAGES) @(posedge clock);
      if (mismatches == 0) begin
         $display("triangle_affine_transform_normal_core_tb: PASS");
      end else begin
         $display("triangle_affine_transform_normal_core_tb: FAIL");
      end
      $finish;
   end

endmodule
